// File: hw/rtl/gb3_pkg.sv
// ============================================================================
// gb3_pkg
// Shared types and constants of the streaming 3x3 gaussian blur core.
// ============================================================================
`default_nettype none

package gb3_pkg;

    // configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    // row geometry
    localparam int HGT_W     = 13;
    localparam int OUT_ROW_W = 12;
    localparam logic [HGT_W-1:0] HEIGHT_LIMIT = 13'd4096;

    // item kinds
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // channel lanes of a stored pixel
    localparam int NUM_CH   = 3;
    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    typedef logic [NUM_CH-1:0][7:0] pixel_t;

    typedef struct packed {
        logic       action;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_last;
    } out_item_t;

    // edge replication and frame end of one output pixel
    typedef struct packed {
        logic row_first;
        logic row_last;
        logic col_first;
        logic col_last;
        logic last;
    } win_flags_t;

endpackage

`default_nettype wire

// File: hw/rtl/gaussian_blur_3x3_rgb_core.sv
// ============================================================================
// gaussian_blur_3x3_rgb_core
// Raster-order RGB stream blurred by a 1-2-1 x 1-2-1 kernel over 16 with
// edge replication, built around two line memories and a 3x3 window.
// ============================================================================
// pipeline: stage a, stage b and the output register; a result follows the
//   transfer that completes its neighborhood, one row plus one pixel after its
//   center pixel; throughput one item per cycle unless the result side stalls,
//   set by the single read-modify-write pass through the line memories per item
// reset: synchronous active-low aresetn clears counters, window and pipeline
//   valids and resets the configuration and active geometry; line memories are
//   not cleared (rows outside the image are replaced by replication before use)
`default_nettype none

module gaussian_blur_3x3_rgb_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // pixel input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire gb3_pkg::in_item_t             s_data,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output gb3_pkg::out_item_t                 m_data,
    // configuration writes
    input  wire logic                          cfg_we,
    input  wire logic [gb3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gb3_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int DIM_W = $clog2(MAX_WIDTH + 1);

    // ------------------------------------------------------------------
    // declarations
    // ------------------------------------------------------------------
    // configuration and active geometry
    logic [gb3_pkg::CFG_W-1:0]     cfg_width_reg;
    logic [gb3_pkg::CFG_W-1:0]     cfg_height_reg;
    logic [DIM_W-1:0]              act_w_reg;
    logic [gb3_pkg::HGT_W-1:0]     act_h_reg;
    logic [DIM_W-1:0]              eff_w;
    logic [gb3_pkg::HGT_W-1:0]     eff_h;

    // position counters
    logic [COL_W-1:0]              in_col_reg,  in_col_next;
    logic [gb3_pkg::HGT_W-1:0]     in_row_reg,  in_row_next;
    logic [COL_W-1:0]              out_col_reg, out_col_next;
    logic [gb3_pkg::OUT_ROW_W-1:0] out_row_reg, out_row_next;

    // item decode at the input transfer
    logic                          in_take;
    logic                          is_pixel;
    logic                          frame_start;
    logic                          in_frame;
    logic                          item_active;
    logic                          item_emit;
    logic                          col_end;
    logic                          a_load;
    gb3_pkg::win_flags_t           flags;
    gb3_pkg::pixel_t               incoming;

    // stage a: line memory read in flight
    logic                          a_valid_reg;
    logic [COL_W-1:0]              a_col_reg;
    gb3_pkg::pixel_t               a_pix_reg;
    logic                          a_emit_reg;
    gb3_pkg::win_flags_t           a_flags_reg;
    gb3_pkg::pixel_t               above_rd_reg;
    gb3_pkg::pixel_t               two_rd_reg;
    logic                          fwd_reg;
    gb3_pkg::pixel_t               fwd_mid_reg;
    gb3_pkg::pixel_t               fwd_top_reg;
    gb3_pkg::pixel_t               mid_eff;
    gb3_pkg::pixel_t               top_eff;

    // line memories
    gb3_pkg::pixel_t               mem_above [MAX_WIDTH];
    gb3_pkg::pixel_t               mem_two   [MAX_WIDTH];

    // window [row][col], row 0 oldest line, col 2 newest column
    gb3_pkg::pixel_t               win_reg [3][3];

    // stage b: window holds the neighborhood of this output
    logic                          b_valid_reg;
    gb3_pkg::win_flags_t           b_flags_reg;

    // output register
    logic                          o_valid_reg;
    gb3_pkg::out_item_t            o_data_reg;
    gb3_pkg::out_item_t            o_data_next;

    // stage handshakes
    logic                          out_en;
    logic                          b_free;
    logic                          a_adv;
    logic                          a_free;

    // kernel datapath
    logic [9:0]                    vsum [3][gb3_pkg::NUM_CH];
    logic [11:0]                   hsum [gb3_pkg::NUM_CH];
    logic [1:0]                    top_sel, bot_sel, left_sel, right_sel;

    // ------------------------------------------------------------------
    // geometry clamps
    // ------------------------------------------------------------------
    function automatic logic [DIM_W-1:0] clamp_width(input logic [gb3_pkg::CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > 32'(MAX_WIDTH)) begin
            r = DIM_W'(MAX_WIDTH);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    function automatic logic [gb3_pkg::HGT_W-1:0] clamp_height(
        input logic [gb3_pkg::CFG_W-1:0] v
    );
        logic [gb3_pkg::HGT_W-1:0] r;
        if (v == '0) begin
            r = gb3_pkg::HGT_W'(1);
        end else if (v > gb3_pkg::HEIGHT_LIMIT) begin
            r = gb3_pkg::HEIGHT_LIMIT;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // handshakes: every stage moves when the one after it is free
    // ------------------------------------------------------------------
    assign out_en  = !o_valid_reg || m_ready;
    assign b_free  = !b_valid_reg || out_en;
    assign a_adv   = a_valid_reg && b_free;
    assign a_free  = !a_valid_reg || b_free;
    assign s_ready = a_free;
    assign in_take = s_valid && s_ready;

    // ------------------------------------------------------------------
    // item decode
    // ------------------------------------------------------------------
    always_comb begin
        is_pixel    = (s_data.action == gb3_pkg::ACT_PIXEL);
        // geometry is sampled by the first pixel of a frame
        frame_start = is_pixel && (in_row_reg == '0) && (in_col_reg == '0);
        eff_w       = frame_start ? clamp_width(cfg_width_reg)   : act_w_reg;
        eff_h       = frame_start ? clamp_height(cfg_height_reg) : act_h_reg;
        in_frame    = (in_row_reg < eff_h);
        // a drain tick inside the frame is a no-op
        item_active = !(in_frame && !is_pixel);
        // past the last row the item feeds zeros and flushes the tail
        incoming                  = '0;
        if (in_frame) begin
            incoming[gb3_pkg::CH_RED]   = s_data.red_in;
            incoming[gb3_pkg::CH_GREEN] = s_data.green_in;
            incoming[gb3_pkg::CH_BLUE]  = s_data.blue_in;
        end
        item_emit = (in_row_reg > gb3_pkg::HGT_W'(1))
                 || ((in_row_reg == gb3_pkg::HGT_W'(1)) && (in_col_reg != '0));
        col_end   = (DIM_W'(in_col_reg) + DIM_W'(1)) >= eff_w;

        flags.row_first = (out_row_reg == '0);
        flags.row_last  = (gb3_pkg::HGT_W'(out_row_reg) + gb3_pkg::HGT_W'(1)) >= eff_h;
        flags.col_first = (out_col_reg == '0);
        flags.col_last  = (DIM_W'(out_col_reg) + DIM_W'(1)) >= eff_w;
        flags.last      = flags.row_last && flags.col_last;

        a_load = in_take && item_active;
    end

    // ------------------------------------------------------------------
    // position counters
    // ------------------------------------------------------------------
    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (a_load) begin
            if (item_emit && flags.last) begin
                // frame done, start over
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else begin
                if (col_end) begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + gb3_pkg::HGT_W'(1);
                end else begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
                if (item_emit) begin
                    if (flags.col_last) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + gb3_pkg::OUT_ROW_W'(1);
                    end else begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ------------------------------------------------------------------
    // configuration registers and sampled geometry
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= gb3_pkg::WIDTH_RESET;
            cfg_height_reg <= gb3_pkg::HEIGHT_RESET;
            act_w_reg      <= clamp_width(gb3_pkg::WIDTH_RESET);
            act_h_reg      <= clamp_height(gb3_pkg::HEIGHT_RESET);
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    gb3_pkg::REG_IMAGE_WIDTH:  cfg_width_reg  <= cfg_wdata;
                    gb3_pkg::REG_IMAGE_HEIGHT: cfg_height_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (in_take && frame_start) begin
                act_w_reg <= eff_w;
                act_h_reg <= eff_h;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage a: read both line memories at the input column
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_free) begin
            a_valid_reg <= a_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_col_reg   <= in_col_reg;
            a_pix_reg   <= incoming;
            a_emit_reg  <= item_emit;
            a_flags_reg <= flags;
            // the item leaving stage a writes this column in the same edge
            // (one-pixel rows), so its write data is forwarded
            fwd_reg     <= a_adv && (a_col_reg == in_col_reg);
            fwd_mid_reg <= a_pix_reg;
            fwd_top_reg <= mid_eff;
        end
    end

    // line memories: synchronous read, written as the item leaves stage a
    always_ff @(posedge aclk) begin
        if (a_load) begin
            above_rd_reg <= mem_above[in_col_reg];
            two_rd_reg   <= mem_two[in_col_reg];
        end
        if (a_adv) begin
            mem_above[a_col_reg] <= a_pix_reg;
            mem_two[a_col_reg]   <= mid_eff;
        end
    end

    assign mid_eff = fwd_reg ? fwd_mid_reg : above_rd_reg;
    assign top_eff = fwd_reg ? fwd_top_reg : two_rd_reg;

    // ------------------------------------------------------------------
    // window shift: new column enters on the right
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (a_adv) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= top_eff;
            win_reg[1][2] <= mid_eff;
            win_reg[2][2] <= a_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage b: window is final for this output
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_free) begin
            b_valid_reg <= a_valid_reg && a_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv) begin
            b_flags_reg <= a_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // kernel: vertical 1-2-1 per column, then horizontal 1-2-1, over 16
    // ------------------------------------------------------------------
    always_comb begin
        // edge replication picks the center row or column
        top_sel   = b_flags_reg.row_first ? 2'd1 : 2'd0;
        bot_sel   = b_flags_reg.row_last  ? 2'd1 : 2'd2;
        left_sel  = b_flags_reg.col_first ? 2'd1 : 2'd0;
        right_sel = b_flags_reg.col_last  ? 2'd1 : 2'd2;
        for (int c = 0; c < 3; c++) begin
            for (int ch = 0; ch < gb3_pkg::NUM_CH; ch++) begin
                vsum[c][ch] = 10'(win_reg[top_sel][c][ch])
                            + {1'b0, win_reg[1][c][ch], 1'b0}
                            + 10'(win_reg[bot_sel][c][ch]);
            end
        end
        for (int ch = 0; ch < gb3_pkg::NUM_CH; ch++) begin
            hsum[ch] = 12'(vsum[left_sel][ch])
                     + {1'b0, vsum[1][ch], 1'b0}
                     + 12'(vsum[right_sel][ch]);
        end
        o_data_next.red_out    = hsum[gb3_pkg::CH_RED][11:4];
        o_data_next.green_out  = hsum[gb3_pkg::CH_GREEN][11:4];
        o_data_next.blue_out   = hsum[gb3_pkg::CH_BLUE][11:4];
        o_data_next.frame_last = b_flags_reg.last;
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (out_en) begin
            o_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && b_valid_reg) begin
            o_data_reg <= o_data_next;
        end
    end

    assign m_valid = o_valid_reg;
    assign m_data  = o_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/gb3_checker.sv
// ============================================================================
// gb3_checker
// Port-level checks of the gaussian blur core, attached by bind.
// ============================================================================
`default_nettype none

module gb3_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire gb3_pkg::out_item_t m_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result changed while stalled");

    // with no result pending the pipeline has room for a transfer
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

endmodule

bind gaussian_blur_3x3_rgb_core gb3_checker u_gb3_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// File: tb/gaussian_blur_3x3_rgb_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// gaussian_blur_3x3_rgb_core_tb
// Self-checking bench for the streaming rgb blur core. Frames of random
// geometry are pushed through the pixel channel with random gaps on both
// sides. A line-store and window predictor works out every blurred pixel at
// its input transfer, and each result transfer is checked against it.
// ============================================================================

module gaussian_blur_3x3_rgb_core_tb;

    localparam int MAX_WIDTH = 4096;

    // clock, reset and block ports
    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    gb3_pkg::in_item_t             s_data = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    gb3_pkg::out_item_t            m_data;
    logic                          cfg_we = 1'b0;
    logic [gb3_pkg::CFG_IDX_W-1:0] cfg_index = gb3_pkg::REG_IMAGE_WIDTH;
    logic [gb3_pkg::CFG_W-1:0]     cfg_wdata = '0;

    // pixels waiting for the driver, blurred pixels waiting for the block
    gb3_pkg::in_item_t  pixel_queue [$];
    gb3_pkg::out_item_t blurred_due [$];
    gb3_pkg::out_item_t blur_res;
    gb3_pkg::out_item_t want;

    int          fail_count = 0;
    int unsigned item_total = 0;

    // traffic shaping shared by the stimulus and the two channel processes
    bit steady_stream  = 1'b0;
    bit pressure_armed = 1'b0;
    bit pressure_done  = 1'b0;
    int hold_left      = 0;

    // predictor state: register copies, sampled geometry, stores, counters
    logic [gb3_pkg::CFG_W-1:0] width_reg  = gb3_pkg::WIDTH_RESET;
    logic [gb3_pkg::CFG_W-1:0] height_reg = gb3_pkg::HEIGHT_RESET;
    int unsigned               act_width  = 640;
    int unsigned               act_height = 480;
    gb3_pkg::pixel_t           above_row     [MAX_WIDTH] = '{default: '0};
    gb3_pkg::pixel_t           two_above_row [MAX_WIDTH] = '{default: '0};
    gb3_pkg::pixel_t           win [3][3] = '{default: '0};
    int unsigned               in_col  = 0;
    int unsigned               in_row  = 0;
    int unsigned               out_col = 0;
    int unsigned               out_row = 0;

    gaussian_blur_3x3_rgb_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // zero counts as one, anything past the top saturates
    function automatic int unsigned clamp_dim(input logic [gb3_pkg::CFG_W-1:0] v,
                                              input int unsigned top);
        if (v == '0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    // advance the blur predictor by one input transfer; returns 1 when a
    // blurred pixel comes out of it
    function automatic bit blur_pixel(input gb3_pkg::in_item_t item,
                                      output gb3_pkg::out_item_t res);
        int unsigned     wt [3] = '{1, 2, 1};
        int unsigned     rsel [3];
        int unsigned     csel [3];
        int unsigned     sum [gb3_pkg::NUM_CH];
        int unsigned     col;
        gb3_pkg::pixel_t incoming;
        gb3_pkg::pixel_t top_px;
        gb3_pkg::pixel_t mid_px;
        bit              is_pixel;
        bit              emit;
        bit              last;
        is_pixel = (item.action == gb3_pkg::ACT_PIXEL);
        incoming = '0;
        res      = '0;
        sum      = '{0, 0, 0};

        // geometry is sampled by the first pixel of a frame
        if (is_pixel && in_row == 0 && in_col == 0) begin
            act_width  = clamp_dim(width_reg, MAX_WIDTH);
            act_height = clamp_dim(height_reg, gb3_pkg::HEIGHT_LIMIT);
        end
        // inside the frame a drain does nothing; past it every item drains
        if (in_row < act_height) begin
            if (!is_pixel) return 1'b0;
            incoming = {item.red_in, item.green_in, item.blue_in};
        end

        col = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
        top_px = two_above_row[col];
        mid_px = above_row[col];
        two_above_row[col] = mid_px;
        above_row[col]     = incoming;

        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top_px;
        win[1][2] = mid_px;
        win[2][2] = incoming;

        emit = in_row > 1 || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= act_width) begin
            in_col = 0;
            in_row++;
        end
        if (!emit) return 1'b0;

        // edge replication: out-of-image neighbors fold onto the center
        rsel[0] = (out_row == 0) ? 1 : 0;
        rsel[1] = 1;
        rsel[2] = (out_row + 1 >= act_height) ? 1 : 2;
        csel[0] = (out_col == 0) ? 1 : 0;
        csel[1] = 1;
        csel[2] = (out_col + 1 >= act_width) ? 1 : 2;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                for (int ch = 0; ch < gb3_pkg::NUM_CH; ch++) begin
                    sum[ch] += win[rsel[r]][csel[k]][ch] * wt[r] * wt[k];
                end
            end
        end
        last = (out_row + 1 >= act_height) && (out_col + 1 >= act_width);
        res.red_out    = 8'(sum[gb3_pkg::CH_RED] >> 4);
        res.green_out  = 8'(sum[gb3_pkg::CH_GREEN] >> 4);
        res.blue_out   = 8'(sum[gb3_pkg::CH_BLUE] >> 4);
        res.frame_last = last;

        if (last) begin
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        end else begin
            out_col++;
            if (out_col >= act_width) begin
                out_col = 0;
                out_row++;
            end
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // input side: feeds pixel_queue into the block and runs the predictor on
    // every accepted transfer
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                if (blur_pixel(s_data, blur_res)) blurred_due.push_back(blur_res);
            end
            // a new item may go out once the current one is gone
            if (!s_valid || s_ready) begin
                if (pixel_queue.size() != 0 && (steady_stream || $urandom_range(99) >= 37)) begin
                    s_valid <= 1'b1;
                    s_data  <= pixel_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side: random back-pressure, one long hold-off when armed, and a
    // field-by-field check of every result transfer
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (blurred_due.size() == 0) begin
                    $error("result transfer with nothing expected: %p", m_data);
                    fail_count++;
                end else begin
                    want = blurred_due.pop_front();
                    if (m_data.red_out !== want.red_out) begin
                        $error("red_out expected %0d got %0d", want.red_out, m_data.red_out);
                        fail_count++;
                    end
                    if (m_data.green_out !== want.green_out) begin
                        $error("green_out expected %0d got %0d",
                               want.green_out, m_data.green_out);
                        fail_count++;
                    end
                    if (m_data.blue_out !== want.blue_out) begin
                        $error("blue_out expected %0d got %0d", want.blue_out, m_data.blue_out);
                        fail_count++;
                    end
                    if (m_data.frame_last !== want.frame_last) begin
                        $error("frame_last expected %0d got %0d",
                               want.frame_last, m_data.frame_last);
                        fail_count++;
                    end
                end
            end
            // the long hold-off starts once results are actually waiting,
            // so the sender keeps offering and the block backs up
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (pressure_armed && !pressure_done && m_valid) begin
                hold_left     = 400;
                pressure_done = 1'b1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady_stream || ($urandom_range(99) >= 37);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers; items are queued on the falling edge so the driver
    // never races the queue
    // ------------------------------------------------------------------------
    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        pixel_queue.push_back(gb3_pkg::in_item_t'{action: gb3_pkg::ACT_PIXEL,
                                                  red_in: r, green_in: g, blue_in: b});
    endtask

    // drains carry random junk in the channel fields
    task automatic push_drain();
        pixel_queue.push_back(gb3_pkg::in_item_t'{action: gb3_pkg::ACT_DRAIN,
                                                  red_in: 8'($urandom()),
                                                  green_in: 8'($urandom()),
                                                  blue_in: 8'($urandom())});
    endtask

    // block idle: everything accepted, every blurred pixel seen, then the pipeline
    // left to settle
    task automatic wait_idle();
        do @(negedge aclk);
        while (pixel_queue.size() != 0 || s_valid || blurred_due.size() != 0);
        repeat (10) @(negedge aclk);
    endtask

    task automatic set_geometry(input logic [gb3_pkg::CFG_W-1:0] w,
                                input logic [gb3_pkg::CFG_W-1:0] h);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= gb3_pkg::REG_IMAGE_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_index <= gb3_pkg::REG_IMAGE_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_we <= 1'b0;
        width_reg  = w;
        height_reg = h;
        @(negedge aclk);
    endtask

    // mostly random channels, with the rails showing up often
    function automatic logic [7:0] pick_level();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    // zero now and then to exercise the minimum clamp
    function automatic logic [gb3_pkg::CFG_W-1:0] pick_size(input int unsigned top);
        if ($urandom_range(11) == 0) return '0;
        return gb3_pkg::CFG_W'($urandom_range(top, 1));
    endfunction

    // one whole frame at the current register geometry, sprinkled with early
    // drains, late pixels in the tail, and optionally a register write in the
    // middle that must only land on the next frame
    task automatic send_frame(input bit retune_mid);
        int unsigned fw;
        int unsigned fh;
        int unsigned total;
        int unsigned split_at;
        fw       = clamp_dim(width_reg, MAX_WIDTH);
        fh       = clamp_dim(height_reg, gb3_pkg::HEIGHT_LIMIT);
        total    = fw * fh;
        split_at = (retune_mid && total > 1) ? $urandom_range(total - 1, 1) : 0;
        if ($urandom_range(9) == 0) push_drain();
        for (int unsigned n = 0; n < total; n++) begin
            if (n != 0 && n == split_at) begin
                wait_idle();
                set_geometry(pick_size(10), pick_size(5));
            end
            if (n != 0 && $urandom_range(24) == 0) push_drain();
            push_pixel(pick_level(), pick_level(), pick_level());
        end
        // one row plus one item flushes the frame
        for (int unsigned n = 0; n <= fw; n++) begin
            if ($urandom_range(9) < 3) push_pixel(pick_level(), pick_level(), pick_level());
            else push_drain();
        end
        if ($urandom_range(7) == 0) push_drain();
        item_total += total + fw + 1;
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: 3x2 frame with rails and alternating bit patterns
        set_geometry(13'd3, 13'd2);
        push_drain();                      // drain before any pixel
        push_pixel(8'h00, 8'h00, 8'h00);
        push_pixel(8'hFF, 8'hFF, 8'hFF);
        push_pixel(8'hAA, 8'h55, 8'hAA);
        wait_idle();
        // zero geometry written mid-frame, only the next frame sees it
        set_geometry(13'd0, 13'd0);
        push_drain();                      // drain inside the frame
        push_pixel(8'h55, 8'hAA, 8'h55);
        push_pixel(8'hFF, 8'h00, 8'hFF);
        push_pixel(8'h01, 8'h80, 8'hFE);
        push_drain();
        push_drain();
        push_drain();
        push_pixel(8'h12, 8'h34, 8'h56);   // late pixel flushes like a drain
        push_drain();                      // early drain of the next frame
        // 1x1 frame from the zero geometry
        push_pixel(8'hFF, 8'hFF, 8'hFF);
        push_drain();
        push_drain();
        wait_idle();
        // single column
        set_geometry(13'd1, 13'd3);
        push_pixel(8'h00, 8'hFF, 8'h7F);
        push_pixel(8'hFF, 8'h00, 8'h80);
        push_pixel(8'h7F, 8'h80, 8'h00);
        push_drain();
        push_drain();
        wait_idle();

        // random small frames
        while (item_total < 950) begin
            if ($urandom_range(3) == 0) begin
                wait_idle();
                set_geometry(pick_size($urandom_range(3) == 0 ? 40 : 8), pick_size(6));
            end
            send_frame($urandom_range(5) == 0);
        end
        wait_idle();

        // wide rows with the receiver holding off for a while
        set_geometry(13'd40, 13'd4);
        pressure_armed = 1'b1;
        send_frame(1'b0);
        wait_idle();
        // streamed without gaps, a single column first
        steady_stream = 1'b1;
        set_geometry(13'd1, 13'd24);
        send_frame(1'b0);
        wait_idle();
        set_geometry(13'd16, 13'd6);
        send_frame(1'b0);
        wait_idle();
        steady_stream = 1'b0;

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/gb3_pkg.sv
hw/rtl/gaussian_blur_3x3_rgb_core.sv
hw/rtl/gb3_checker.sv
tb/gaussian_blur_3x3_rgb_core_tb.sv
